// ----- hdl/csr_pkg.sv -----
// shared types, constants and the device-info table of the subcommand responder
`default_nettype none
package csr_pkg;

  localparam int unsigned CNT_W   = 5;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned RL_W    = 5;
  localparam int unsigned NPARAM  = 5;

  localparam logic [CNT_W-1:0] COUNT_MAX       = 5'd31;
  localparam logic [CNT_W-1:0] SUBCMD_POS      = 5'd10;
  localparam logic [CNT_W-1:0] PARAM_POS       = 5'd11;
  localparam logic [CNT_W-1:0] MIN_REPLY_COUNT = 5'd11;
  localparam logic [CNT_W-1:0] FLASH_MIN_COUNT = 5'd16;

  localparam logic [POS_W-1:0] HDR_LEN       = 7'd12;
  localparam logic [LEN_W-1:0] INFO_LEN      = 6'd12;
  localparam logic [LEN_W-1:0] FLASH_HDR_LEN = 6'd5;

  localparam logic [7:0] SUBCMD_INFO  = 8'h02;
  localparam logic [7:0] SUBCMD_FLASH = 8'h10;
  localparam logic [7:0] REPLY_FLAG   = 8'h80;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_INFO,
    KIND_FLASH
  } csr_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } csr_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } csr_out_t;

  // everything the reply generator needs, captured at packet end
  typedef struct packed {
    csr_kind_t              kind;
    logic [7:0]             timer;
    logic [7:0]             subcmd;
    logic [3:0][7:0]        addr;
    logic [RL_W-1:0]        read_len;
    logic [POS_W-1:0]       total;
  } csr_desc_t;

  function automatic logic [7:0] info_byte(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'h03;
      4'd1:    v = 8'h48;
      4'd2:    v = 8'h03;
      4'd3:    v = 8'h02;
      4'd10:   v = 8'h01;
      4'd11:   v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/controller_subcommand_responder_top.sv -----
// top level of the subcommand responder: packet parser and reply launch
//
//  channel | direction | payload              | handshake
//  pkt     | in        | in_byte, in_last     | pkt_valid / pkt_stall
//  rsp     | out       | out_byte, out_last   | rsp_valid / rsp_stall
//
// packet bytes are taken one per cycle unless stalled; each is parsed in the cycle it arrives
// a reply of 12 to 12 + MAX_REPLY bytes leaves one byte per cycle, unless rsp_stall holds it, from the
// generator's output register, so its length sets the spacing of replies
// while a reply is still being generated, only a final packet byte is stalled
// rst is synchronous; it clears the byte count, subcommand, timer and generator
`default_nettype none
module controller_subcommand_responder_top #(
  parameter int unsigned MAX_REPLY      = 30,
  parameter int unsigned FLASH_READ_MAX = 29
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pkt_valid,
  output logic                  pkt_stall,
  input  wire csr_pkg::csr_in_t pkt,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output csr_pkg::csr_out_t     rsp
);
  import csr_pkg::*;

  // parser state
  logic [CNT_W-1:0]       byte_count;
  logic [7:0]             subcommand_id;
  logic [NPARAM-1:0][7:0] param_bytes;
  logic [7:0]             reply_timer;

  // values after the current byte is folded in
  logic [CNT_W-1:0]       count_next;
  logic [7:0]             subcmd_next;
  logic [NPARAM-1:0][7:0] param_next;
  logic [CNT_W-1:0]       pidx;

  logic                   accept;
  logic                   launch;
  logic                   gen_busy;
  logic [RL_W-1:0]        read_len;
  logic [LEN_W-1:0]       data_len;
  logic [LEN_W-1:0]       data_len_cap;
  csr_desc_t              desc;

  // only a packet end can need the generator, so only that byte waits
  assign pkt_stall = pkt.in_last && gen_busy;
  assign accept    = pkt_valid && !pkt_stall;

  assign pidx = byte_count - PARAM_POS;

  always_comb begin
    count_next  = (byte_count < COUNT_MAX) ? byte_count + 5'd1 : byte_count;
    subcmd_next = (byte_count == SUBCMD_POS) ? pkt.in_byte : subcommand_id;
    param_next  = param_bytes;
    if (byte_count >= PARAM_POS && byte_count < PARAM_POS + 5'(NPARAM)) begin
      param_next[pidx[2:0]] = pkt.in_byte;
    end
  end

  // a reply goes out when a packet of 11 or more bytes ends
  assign launch = accept && pkt.in_last && (count_next >= MIN_REPLY_COUNT);

  // flash read length, capped
  assign read_len = (param_next[4] > 8'(FLASH_READ_MAX)) ? RL_W'(FLASH_READ_MAX)
                                                           : param_next[4][RL_W-1:0];

  always_comb begin
    desc.timer    = reply_timer;
    desc.subcmd   = subcmd_next;
    desc.addr     = param_next[3:0];
    desc.read_len = read_len;
    if (subcmd_next == SUBCMD_INFO) begin
      desc.kind = KIND_INFO;
      data_len  = INFO_LEN;
    end else if (subcmd_next == SUBCMD_FLASH && count_next >= FLASH_MIN_COUNT) begin
      // short flash read packets get a header only
      desc.kind = KIND_FLASH;
      data_len  = FLASH_HDR_LEN + LEN_W'(read_len);
    end else begin
      desc.kind = KIND_NONE;
      data_len  = '0;
    end
    // reply data truncated to MAX_REPLY bytes
    data_len_cap = (data_len > LEN_W'(MAX_REPLY)) ? LEN_W'(MAX_REPLY) : data_len;
    desc.total   = HDR_LEN + POS_W'(data_len_cap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      subcommand_id <= '0;
      reply_timer   <= '0;
    end else if (accept) begin
      subcommand_id <= subcmd_next;
      byte_count    <= pkt.in_last ? '0 : count_next;
      if (launch) begin
        reply_timer <= reply_timer + 8'd1;
      end
    end
  end

  // parameter bytes are only read after this packet has written them all
  always_ff @(posedge clk) begin
    if (accept) begin
      param_bytes <= param_next;
    end
  end

  csr_reply_gen u_gen (
    .clk       (clk),
    .rst       (rst),
    .load      (launch),
    .desc_in   (desc),
    .busy      (gen_busy),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

// ----- hdl/csr_reply_gen.sv -----
// reply generator: walks one captured descriptor out as report bytes
`default_nettype none
module csr_reply_gen (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire csr_pkg::csr_desc_t desc_in,
  output logic                    busy,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output csr_pkg::csr_out_t       rsp
);
  import csr_pkg::*;

  csr_desc_t        desc;
  logic             desc_valid;
  logic [POS_W-1:0] pos;
  logic             advance;
  logic [7:0]       cur_byte;
  logic             cur_last;
  logic [POS_W-1:0] dpos;

  assign busy     = desc_valid;
  assign advance  = desc_valid && (!rsp_valid || !rsp_stall);
  assign cur_last = (pos + 7'd1) == desc.total;
  assign dpos     = pos - HDR_LEN;

  always_comb begin
    cur_byte = 8'h00;
    if (pos < HDR_LEN) begin
      if (pos == 7'd0) begin
        cur_byte = desc.timer;
      end else if (pos inside {7'd5, 7'd8}) begin
        cur_byte = REPLY_FLAG;
      end else if (pos == 7'd11) begin
        cur_byte = REPLY_FLAG | desc.subcmd;
      end
    end else begin
      case (desc.kind)
        KIND_INFO: begin
          cur_byte = info_byte(dpos[3:0]);
        end
        KIND_FLASH: begin
          if (dpos < 7'd4) begin
            cur_byte = desc.addr[dpos[1:0]];
          end else if (dpos == 7'd4) begin
            cur_byte = 8'(desc.read_len);
          end
        end
        default: cur_byte = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
      rsp_valid  <= 1'b0;
      pos        <= '0;
    end else begin
      if (load && !desc_valid) begin
        desc_valid <= 1'b1;
        pos        <= '0;
      end else if (advance) begin
        pos <= pos + 7'd1;
        if (cur_last) begin
          desc_valid <= 1'b0;
        end
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !desc_valid) begin
      desc <= desc_in;
    end
    if (advance) begin
      rsp.out_byte <= cur_byte;
      rsp.out_last <= cur_last;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/csr_checker.sv -----
// port-level checks of the subcommand responder and their binding
`default_nettype none
module csr_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             pkt_valid,
  input wire logic             pkt_stall,
  input wire csr_pkg::csr_in_t pkt,
  input wire logic             rsp_valid,
  input wire logic             rsp_stall,
  input wire csr_pkg::csr_out_t rsp
);
  import csr_pkg::*;

  // a waiting report byte holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("report byte changed while stalled");

  // a held packet byte stays offered and unchanged
  a_pkt_hold: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_stall |=> pkt_valid && $stable(pkt))
    else $error("packet byte changed while stalled");

  // only the final byte of a packet is ever held back
  a_stall_last: assert property (@(posedge clk) disable iff (rst)
    pkt_stall |-> pkt.in_last)
    else $error("packet stalled on a non-final byte");

  // a report runs without gaps once started
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall && !rsp.out_last |=> rsp_valid)
    else $error("gap inside a report");

  // nothing is offered straight after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("report byte valid after reset");

endmodule

bind controller_subcommand_responder_top csr_checker u_csr_checker (
  .clk       (clk),
  .rst       (rst),
  .pkt_valid (pkt_valid),
  .pkt_stall (pkt_stall),
  .pkt       (pkt),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
`default_nettype wire
